// ===== sv/rpt_pkg.sv =====
// Package of the radar point-target converter: constants, types and conversion functions.
package rpt_pkg;

  // Block dimensions.
  localparam int MAX_TARGETS     = 64;
  localparam int ANGLE_BINS      = 64;
  localparam int ASIN_TABLE_BITS = 10;

  localparam int ANGLE_HALF = ANGLE_BINS / 2;
  localparam int CNT_W      = $clog2(MAX_TARGETS + 1);

  // Fixed-point scale factors and the millimetre to centimetre step.
  localparam longint FIX_SCALE_A = 4096;
  localparam longint FIX_SCALE_B = 409600;
  localparam longint MM_PER_CM   = 10;

  // Encoding modes carried in bits 5:3 of the first flag byte.
  localparam logic [2:0] MODE_FIX_A = 3'd1;
  localparam logic [2:0] MODE_FIX_B = 3'd2;

  // Motion states at or below this value count as moving.
  localparam logic [1:0] MOTION_MOVING_MAX = 2'd1;

  // Arcsine saturation for arguments of magnitude one or more.
  localparam logic [6:0] ASIN_SAT_DEG = 7'd90;

  // Converted range and speed quotients stay below 2^SAT_BITS or saturate.
  localparam int SAT_BITS = 15;
  localparam int PROD_W   = 49;

  typedef enum logic [1:0] {
    SCALE_RAW   = 2'd0,
    SCALE_FIX_A = 2'd1,
    SCALE_FIX_B = 2'd2
  } scale_e;

  typedef enum logic [2:0] {
    CFG_RANGE_STEP  = 3'd0,
    CFG_SPEED_STEP  = 3'd1,
    CFG_VEL_BINS    = 3'd2,
    CFG_ANGLE_LOW   = 3'd3,
    CFG_ANGLE_HIGH  = 3'd4,
    CFG_DROP_MOVING = 3'd5,
    CFG_OFFSET_POS  = 3'd6,
    CFG_OFFSET_NEG  = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic                sat;
    logic [SAT_BITS-1:0] q;
  } div_res_t;

  function automatic int tz_of(input longint d);
    int   n;
    logic run;
    n   = 0;
    run = 1'b1;
    for (int i = 0; i < 63; i++) begin
      if (run && (d[i] == 1'b0)) begin
        n = n + 1;
      end else begin
        run = 1'b0;
      end
    end
    return n;
  endfunction

  function automatic int max3(input int a, input int b, input int c);
    int m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  function automatic longint max3l(input longint a, input longint b, input longint c);
    longint m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  // Range and speed divisors per scale: the power-of-two part is a shift, the
  // odd part a reciprocal multiplication that is exact for quotients below 2^15.
  localparam longint RS_DIV [3] = '{MM_PER_CM, FIX_SCALE_A * MM_PER_CM,
                                    FIX_SCALE_B * MM_PER_CM};
  localparam int     RS_TZ  [3] = '{tz_of(RS_DIV[0]), tz_of(RS_DIV[1]), tz_of(RS_DIV[2])};
  localparam longint RS_ODD [3] = '{RS_DIV[0] >> RS_TZ[0], RS_DIV[1] >> RS_TZ[1],
                                    RS_DIV[2] >> RS_TZ[2]};
  localparam int     RS_LG  [3] = '{$clog2(RS_ODD[0]), $clog2(RS_ODD[1]), $clog2(RS_ODD[2])};
  localparam int     RS_S   [3] = '{SAT_BITS + 2 * RS_LG[0], SAT_BITS + 2 * RS_LG[1],
                                    SAT_BITS + 2 * RS_LG[2]};
  localparam longint RS_M   [3] = '{(longint'(1) << RS_S[0]) / RS_ODD[0] + 1,
                                    (longint'(1) << RS_S[1]) / RS_ODD[1] + 1,
                                    (longint'(1) << RS_S[2]) / RS_ODD[2] + 1};
  localparam longint RS_THR [3] = '{RS_DIV[0] << SAT_BITS, RS_DIV[1] << SAT_BITS,
                                    RS_DIV[2] << SAT_BITS};
  localparam int RS_XW = SAT_BITS + max3(RS_LG[0], RS_LG[1], RS_LG[2]);
  localparam int RS_MW = $clog2(max3l(RS_M[0], RS_M[1], RS_M[2]) + 1);
  localparam int RS_PW = RS_XW + RS_MW;

  // Arcsine denominators per scale, split in the same way.
  localparam longint AD_DEN [3] = '{longint'(ANGLE_BINS), FIX_SCALE_A * ANGLE_HALF,
                                    FIX_SCALE_B * ANGLE_HALF};
  localparam int     AD_TZ  [3] = '{tz_of(AD_DEN[0]), tz_of(AD_DEN[1]), tz_of(AD_DEN[2])};
  localparam longint AD_ODD [3] = '{AD_DEN[0] >> AD_TZ[0], AD_DEN[1] >> AD_TZ[1],
                                    AD_DEN[2] >> AD_TZ[2]};
  localparam int     AD_LG  [3] = '{$clog2(AD_ODD[0]), $clog2(AD_ODD[1]), $clog2(AD_ODD[2])};
  localparam int     AD_S   [3] = '{ASIN_TABLE_BITS + 2 * AD_LG[0],
                                    ASIN_TABLE_BITS + 2 * AD_LG[1],
                                    ASIN_TABLE_BITS + 2 * AD_LG[2]};
  localparam longint AD_M   [3] = '{(longint'(1) << AD_S[0]) / AD_ODD[0] + 1,
                                    (longint'(1) << AD_S[1]) / AD_ODD[1] + 1,
                                    (longint'(1) << AD_S[2]) / AD_ODD[2] + 1};
  localparam int AQ_XW = ASIN_TABLE_BITS + max3(AD_LG[0], AD_LG[1], AD_LG[2]);
  localparam int AQ_MW = $clog2(max3l(AD_M[0], AD_M[1], AD_M[2]) + 1);
  localparam int AQ_PW = AQ_XW + AQ_MW;

  // Rounded-up sine of each whole degree in Q16.
  localparam logic [15:0] SIN_Q16 [90] = '{
    16'd0,     16'd1144,  16'd2288,  16'd3430,  16'd4572,  16'd5712,  16'd6851,  16'd7987,
    16'd9121,  16'd10253, 16'd11381, 16'd12505, 16'd13626, 16'd14743, 16'd15855, 16'd16962,
    16'd18065, 16'd19161, 16'd20252, 16'd21337, 16'd22415, 16'd23487, 16'd24551, 16'd25607,
    16'd26656, 16'd27697, 16'd28730, 16'd29753, 16'd30768, 16'd31773, 16'd32768, 16'd33754,
    16'd34729, 16'd35694, 16'd36648, 16'd37590, 16'd38522, 16'd39441, 16'd40348, 16'd41244,
    16'd42126, 16'd42996, 16'd43853, 16'd44696, 16'd45526, 16'd46341, 16'd47143, 16'd47930,
    16'd48703, 16'd49461, 16'd50204, 16'd50932, 16'd51644, 16'd52340, 16'd53020, 16'd53684,
    16'd54332, 16'd54964, 16'd55578, 16'd56176, 16'd56756, 16'd57320, 16'd57865, 16'd58394,
    16'd58904, 16'd59396, 16'd59871, 16'd60327, 16'd60764, 16'd61184, 16'd61584, 16'd61966,
    16'd62329, 16'd62673, 16'd62998, 16'd63303, 16'd63590, 16'd63857, 16'd64104, 16'd64332,
    16'd64541, 16'd64730, 16'd64899, 16'd65048, 16'd65177, 16'd65287, 16'd65377, 16'd65447,
    16'd65497, 16'd65527
  };

  function automatic int scale_slot(input scale_e s);
    int k;
    case (s)
      SCALE_FIX_A: k = 1;
      SCALE_FIX_B: k = 2;
      default:     k = 0;
    endcase
    return k;
  endfunction

  // Unsigned quotient of a product by the range/speed divisor, with overflow flag.
  function automatic div_res_t divide_sat(input logic [PROD_W-1:0] p, input scale_e s);
    int               k;
    logic [RS_XW-1:0] x;
    logic [RS_PW-1:0] prod;
    div_res_t         r;
    k      = scale_slot(s);
    r.sat  = (64'(p) >= 64'(RS_THR[k]));
    x      = RS_XW'(p >> RS_TZ[k]);
    prod   = RS_PW'(x) * RS_PW'(RS_M[k]);
    r.q    = SAT_BITS'(prod >> RS_S[k]);
    return r;
  endfunction

  // Argument magnitude below the arcsine denominator of its scale.
  function automatic logic angle_in_range(input logic [33:0] mag, input scale_e s);
    int k;
    k = scale_slot(s);
    return (64'(mag) < 64'(AD_DEN[k]));
  endfunction

  // Normalised arcsine argument truncated to ASIN_TABLE_BITS fraction bits.
  function automatic logic [ASIN_TABLE_BITS-1:0] angle_q(input logic [33:0] mag,
                                                         input scale_e s);
    int               k;
    logic [63:0]      y;
    logic [AQ_XW-1:0] x;
    logic [AQ_PW-1:0] prod;
    k    = scale_slot(s);
    y    = 64'(mag) << ASIN_TABLE_BITS;
    x    = AQ_XW'(y >> AD_TZ[k]);
    prod = AQ_PW'(x) * AQ_PW'(AD_M[k]);
    return ASIN_TABLE_BITS'(prod >> AD_S[k]);
  endfunction

  // Largest whole degree whose sine does not exceed the argument.
  function automatic logic [6:0] asin_deg(input logic [ASIN_TABLE_BITS-1:0] q);
    logic [15:0] v;
    logic [6:0]  d;
    v = 16'(q) << (16 - ASIN_TABLE_BITS);
    d = 7'd0;
    for (int k = 1; k < 90; k++) begin
      d = d + 7'(SIN_Q16[k] <= v);
    end
    return d;
  endfunction

endpackage

// ===== sv/radar_point_target_converter.sv =====
// Top level of the radar point-target converter: conversion pipeline, filter and frame count.
//
// Usage: detections enter on the s_axis channel, one per transfer, with s_axis_tlast on the
// last detection of a frame. Each detection is converted to range in centimetres, radial
// speed in centimetres per second and azimuth in whole degrees, then filtered on range,
// angle window and motion state. A kept detection leaves on m_axis with m_axis_tuser set.
// The last detection of a frame always yields a transfer with m_axis_tlast set, carrying
// the number of detections kept in the frame; if that detection itself was dropped, its
// payload fields are zero and m_axis_tuser is clear. Other dropped detections yield no
// transfer, and detections beyond MAX_TARGETS in one frame are ignored.
// Throughput is one detection per cycle while the receiver does not stall. From the input
// transfer to m_axis_tvalid a detection passes an input register, a multiplier stage, a
// stage for the reciprocal divisions and the arcsine quantiser, and the output register
// that holds the filter and the frame counters.
// When the receiver stalls, empty pipeline stages still fill, so s_axis_tready stays high
// until every stage holds a detection; then the whole pipeline holds.
// Reset empties the pipeline, clears the frame counters and loads the register defaults.
// Write the configuration port only while the block is idle; the block does not enforce this.
module radar_point_target_converter
  import rpt_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  // Configuration writes.
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_index_i,
  input  logic [15:0]  cfg_wdata_i,
  // Detection input.
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata from bit 0: flags_a[8], flags_b[8], power[32], range_index[32],
  // speed_index[32], angle_index[32].
  input  logic [143:0] s_axis_tdata,
  input  logic         s_axis_tlast,
  // Result output.
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata from bit 0: out_flags_a[8], out_flags_b[8], range_cm[15], speed_cm_s[16],
  // angle_deg[10], out_power[32], kept_count[7].
  output logic [95:0]  m_axis_tdata,
  // tuser: target_valid[1].
  output logic [0:0]   m_axis_tuser,
  output logic         m_axis_tlast
);

  typedef struct packed {
    logic [7:0]  fa;
    logic [7:0]  fb;
    logic [31:0] pw;
    logic [31:0] ri;
    logic [31:0] vi;
    logic [31:0] ai;
    logic        last;
  } s0_t;

  typedef struct packed {
    logic [7:0]                 fa;
    logic [7:0]                 fb;
    logic [31:0]                pw;
    logic                       last;
    scale_e                     sel;
    logic [PROD_W-1:0]          prange;
    logic [PROD_W-1:0]          pspeed;
    logic                       spd_neg;
    logic                       ang_neg;
    logic                       ang_inr;
    logic [ASIN_TABLE_BITS-1:0] ang_q;
  } s1_t;

  typedef struct packed {
    logic [7:0]  fa;
    logic [7:0]  fb;
    logic [31:0] pw;
    logic        last;
    logic [14:0] rng;
    logic [15:0] spd;
    logic [7:0]  deg;
  } s2_t;

  typedef struct packed {
    logic        target;
    logic [7:0]  fa;
    logic [7:0]  fb;
    logic [14:0] rng;
    logic [15:0] spd;
    logic [9:0]  ang;
    logic [31:0] pw;
    logic        last;
    logic [6:0]  cnt;
  } out_t;

  // Configuration registers.
  logic [15:0] rstep_q, vstep_q;
  logic [7:0]  vbins_q, alow_q, ahigh_q;
  logic        drop_q;
  logic [8:0]  offp_q, offn_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rstep_q <= 16'd75;
      vstep_q <= 16'd100;
      vbins_q <= 8'd64;
      alow_q  <= 8'hA6;
      ahigh_q <= 8'd90;
      drop_q  <= 1'b0;
      offp_q  <= 9'd0;
      offn_q  <= 9'd0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_RANGE_STEP:  rstep_q <= cfg_wdata_i;
        CFG_SPEED_STEP:  vstep_q <= cfg_wdata_i;
        CFG_VEL_BINS:    vbins_q <= cfg_wdata_i[7:0];
        CFG_ANGLE_LOW:   alow_q  <= cfg_wdata_i[7:0];
        CFG_ANGLE_HIGH:  ahigh_q <= cfg_wdata_i[7:0];
        CFG_DROP_MOVING: drop_q  <= cfg_wdata_i[0];
        CFG_OFFSET_POS:  offp_q  <= cfg_wdata_i[8:0];
        CFG_OFFSET_NEG:  offn_q  <= cfg_wdata_i[8:0];
        default: ;
      endcase
    end
  end

  // Pipeline flow control: a stage takes new data when it is empty or its
  // contents move on in the same cycle. Items yielding no result leave the
  // last stage without occupying the output register.
  logic s0_v_q, s1_v_q, s2_v_q, out_v_q;
  logic out_free, free2, free1, free0, take2;

  assign out_free      = !out_v_q || m_axis_tready;
  assign free2         = !s2_v_q || out_free;
  assign free1         = !s1_v_q || free2;
  assign free0         = !s0_v_q || free1;
  assign take2         = s2_v_q && out_free;
  assign s_axis_tready = free0;

  s0_t  s0_q, s0_d;
  s1_t  s1_q, s1_d;
  s2_t  s2_q, s2_d;
  out_t out_q, out_d;

  logic [CNT_W-1:0] items_q, items_d, kept_q, kept_d;
  logic             keep;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q  <= 1'b0;
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      items_q <= '0;
      kept_q  <= '0;
    end else begin
      if (free0)    s0_v_q  <= s_axis_tvalid;
      if (free1)    s1_v_q  <= s0_v_q;
      if (free2)    s2_v_q  <= s1_v_q;
      if (out_free) out_v_q <= take2 && (keep || s2_q.last);
      if (take2) begin
        items_q <= items_d;
        kept_q  <= kept_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (free0 && s_axis_tvalid) s0_q  <= s0_d;
    if (free1 && s0_v_q)        s1_q  <= s1_d;
    if (free2 && s1_v_q)        s2_q  <= s2_d;
    if (take2)                  out_q <= out_d;
  end

  // Input unpacking.
  always_comb begin
    s0_d.fa   = s_axis_tdata[7:0];
    s0_d.fb   = s_axis_tdata[15:8];
    s0_d.pw   = s_axis_tdata[47:16];
    s0_d.ri   = s_axis_tdata[79:48];
    s0_d.vi   = s_axis_tdata[111:80];
    s0_d.ai   = s_axis_tdata[143:112];
    s0_d.last = s_axis_tlast;
  end

  // Stage 1: scale selection, bin wrap-around, products and the normalised
  // arcsine argument.
  logic [2:0]  mode;
  scale_e      sel;
  logic        raw;
  logic [32:0] v_ext, v_sel, v_mag;
  logic [15:0] vs_mag;
  logic [32:0] a_ext, a_sel;
  logic [33:0] num, a_mag;

  always_comb begin
    mode = s0_q.fa[5:3];
    if (mode == MODE_FIX_A) begin
      sel = SCALE_FIX_A;
    end else if (mode == MODE_FIX_B) begin
      sel = SCALE_FIX_B;
    end else begin
      sel = SCALE_RAW;
    end
    raw = (sel == SCALE_RAW);

    // Raw velocity bins at or above half the chirp count are negative.
    v_ext = {s0_q.vi[31], s0_q.vi};
    if (raw && ($signed(s0_q.vi) >= $signed({25'd0, vbins_q[7:1]}))) begin
      v_sel = v_ext - {25'd0, vbins_q};
    end else begin
      v_sel = v_ext;
    end
    v_mag  = v_sel[32] ? (~v_sel + 33'd1) : v_sel;
    vs_mag = vstep_q[15] ? (~vstep_q + 16'd1) : vstep_q;

    // Raw angle bins at or above half the bin count are negative.
    a_ext = {s0_q.ai[31], s0_q.ai};
    if (raw && ($signed(s0_q.ai) >= $signed(32'(ANGLE_HALF)))) begin
      a_sel = a_ext - 33'(ANGLE_BINS);
    end else begin
      a_sel = a_ext;
    end
    num   = raw ? {a_sel, 1'b0} : {a_ext[32], a_ext};
    a_mag = num[33] ? (~num + 34'd1) : num;

    s1_d.fa      = s0_q.fa;
    s1_d.fb      = s0_q.fb;
    s1_d.pw      = s0_q.pw;
    s1_d.last    = s0_q.last;
    s1_d.sel     = sel;
    s1_d.prange  = {17'd0, s0_q.ri} * {33'd0, rstep_q};
    s1_d.pspeed  = {16'd0, v_mag} * {33'd0, vs_mag};
    s1_d.spd_neg = v_sel[32] ^ vstep_q[15];
    s1_d.ang_neg = num[33];
    s1_d.ang_inr = angle_in_range(a_mag, sel);
    s1_d.ang_q   = angle_q(a_mag, sel);
  end

  // Stage 2: reciprocal divisions with saturation and the arcsine quantiser.
  div_res_t   rdiv, vdiv;
  logic [6:0] deg_mag;

  always_comb begin
    rdiv = divide_sat(s1_q.prange, s1_q.sel);
    vdiv = divide_sat(s1_q.pspeed, s1_q.sel);

    s2_d.fa   = s1_q.fa;
    s2_d.fb   = s1_q.fb;
    s2_d.pw   = s1_q.pw;
    s2_d.last = s1_q.last;
    s2_d.rng  = rdiv.sat ? 15'h7FFF : rdiv.q;

    // Speed truncates toward zero, so the sign is applied to the quotient.
    if (vdiv.sat) begin
      s2_d.spd = s1_q.spd_neg ? 16'h8000 : 16'h7FFF;
    end else begin
      s2_d.spd = s1_q.spd_neg ? (16'd0 - {1'b0, vdiv.q}) : {1'b0, vdiv.q};
    end

    deg_mag  = s1_q.ang_inr ? asin_deg(s1_q.ang_q) : ASIN_SAT_DEG;
    s2_d.deg = s1_q.ang_neg ? (8'd0 - {1'b0, deg_mag}) : {1'b0, deg_mag};
  end

  // Output stage: filter, angle offset and frame counters.
  logic             counted, moving;
  logic [9:0]       deg_ext;

  always_comb begin
    counted = (items_q < CNT_W'(MAX_TARGETS));
    moving  = drop_q && (s2_q.fa[7:6] <= MOTION_MOVING_MAX);
    keep    = counted && (kept_q < CNT_W'(MAX_TARGETS)) && (s2_q.rng != 15'd0) &&
              ($signed(s2_q.deg) >= $signed(alow_q)) &&
              ($signed(s2_q.deg) <= $signed(ahigh_q)) && !moving;
    kept_d  = kept_q + CNT_W'(keep);
    items_d = items_q + CNT_W'(counted);
    if (s2_q.last) begin
      kept_d  = '0;
      items_d = '0;
    end

    deg_ext = {{2{s2_q.deg[7]}}, s2_q.deg};

    out_d.target = keep;
    out_d.fa     = keep ? s2_q.fa : 8'd0;
    out_d.fb     = keep ? s2_q.fb : 8'd0;
    out_d.rng    = keep ? s2_q.rng : 15'd0;
    out_d.spd    = keep ? s2_q.spd : 16'd0;
    out_d.pw     = keep ? s2_q.pw : 32'd0;
    out_d.last   = s2_q.last;
    out_d.cnt    = 7'(kept_q + CNT_W'(keep));
    // A zero angle gets no offset.
    if (!keep || (s2_q.deg == 8'd0)) begin
      out_d.ang = 10'd0;
    end else if (s2_q.deg[7]) begin
      out_d.ang = deg_ext + {offn_q[8], offn_q};
    end else begin
      out_d.ang = deg_ext + {offp_q[8], offp_q};
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {out_q.cnt, out_q.pw, out_q.ang, out_q.spd, out_q.rng,
                          out_q.fb, out_q.fa};
  assign m_axis_tuser  = out_q.target;
  assign m_axis_tlast  = out_q.last;

  // The kept count never runs ahead of the detections counted in the frame.
  a_kept_le_seen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    kept_q <= items_q)
    else $error("kept count exceeds detections seen");

  // A transfer without a target only closes a frame.
  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> m_axis_tlast)
    else $error("result without target outside frame end");

  // A transfer without a target carries zero payload fields.
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata[88:0] == 89'd0))
    else $error("dropped frame end carries payload");

  // Counters restart after the last detection of a frame leaves the pipeline.
  a_frame_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take2 && s2_q.last) |=> ((items_q == '0) && (kept_q == '0)))
    else $error("frame counters not cleared");

endmodule

// ===== bench/tb.sv =====
// Self-checking testbench of the radar point-target converter.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rpt_pkg::*;

  // Encoding modes of flags_a bits 5:3; every other mode carries raw bin indices.
  localparam logic [2:0] ENC_RAW        = 3'd0;
  localparam logic [2:0] ENC_FIX_COARSE = 3'd1;
  localparam logic [2:0] ENC_FIX_FINE   = 3'd2;

  // Fixed-point scales, the millimetre to centimetre step and the angle half span.
  localparam longint SCALE_COARSE = 4096;
  localparam longint SCALE_FINE   = 409600;
  localparam longint MM_IN_CM     = 10;
  localparam longint BIN_HALF     = ANGLE_BINS / 2;
  localparam longint COARSE_DEN   = SCALE_COARSE * BIN_HALF;
  localparam longint FINE_DEN     = SCALE_FINE * BIN_HALF;

  // Motion states up to this value are treated as moving.
  localparam logic [1:0] MOVING_STATE_MAX = 2'd1;

  localparam longint RANGE_MAX_CM = 32767;
  localparam longint SPEED_MAX    = 32767;
  localparam longint SPEED_MIN    = -32768;
  localparam int     RIGHT_ANGLE  = 90;
  localparam int     NUM_REGS     = 8;

  // Bench timing: receiver hold-off, settling after the last result, watchdog limit.
  localparam int HOLD_CYCLES   = 80;
  localparam int SETTLE_CYCLES = 8;
  localparam int STUCK_LIMIT   = 2000;

  // Sine of each whole degree in Q16, rounded up.
  localparam int SINE_CEIL_Q16 [90] = '{
    0, 1144, 2288, 3430, 4572, 5712, 6851, 7987, 9121, 10253,
    11381, 12505, 13626, 14743, 15855, 16962, 18065, 19161, 20252, 21337,
    22415, 23487, 24551, 25607, 26656, 27697, 28730, 29753, 30768, 31773,
    32768, 33754, 34729, 35694, 36648, 37590, 38522, 39441, 40348, 41244,
    42126, 42996, 43853, 44696, 45526, 46341, 47143, 47930, 48703, 49461,
    50204, 50932, 51644, 52340, 53020, 53684, 54332, 54964, 55578, 56176,
    56756, 57320, 57865, 58394, 58904, 59396, 59871, 60327, 60764, 61184,
    61584, 61966, 62329, 62673, 62998, 63303, 63590, 63857, 64104, 64332,
    64541, 64730, 64899, 65048, 65177, 65287, 65377, 65447, 65497, 65527
  };

  // One detection as it enters the block.
  typedef struct {
    logic [7:0]         flags_a;
    logic [7:0]         flags_b;
    logic [31:0]        power;
    logic [31:0]        range_index;
    logic signed [31:0] speed_index;
    logic signed [31:0] angle_index;
    logic               last;
  } detection_t;

  // One converted target as it leaves the block.
  typedef struct {
    logic               target_valid;
    logic [7:0]         flags_a;
    logic [7:0]         flags_b;
    logic [14:0]        range_cm;
    logic signed [15:0] speed_cm_s;
    logic signed [9:0]  angle_deg;
    logic [31:0]        power;
    logic               frame_done;
    logic [6:0]         kept_count;
  } target_t;

  // Converts each accepted detection to the target it should yield and checks the
  // targets that leave the block against them in order.
  class target_scoreboard;
    target_t expected_q [$];
    longint  range_step, speed_step, velocity_bins, angle_low, angle_high;
    longint  offset_pos, offset_neg;
    bit      drop_moving;
    int      kept_so_far, items_seen;
    int      errors, items_noted, results_seen, frames_seen, targets_kept;

    function new();
      range_step    = 75;
      speed_step    = 100;
      velocity_bins = 64;
      angle_low     = -90;
      angle_high    = 90;
      drop_moving   = 1'b0;
      offset_pos    = 0;
      offset_neg    = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, int value);
      case (idx)
        CFG_RANGE_STEP:  range_step    = longint'(value[15:0]);
        CFG_SPEED_STEP:  speed_step    = $signed(value[15:0]);
        CFG_VEL_BINS:    velocity_bins = longint'(value[7:0]);
        CFG_ANGLE_LOW:   angle_low     = $signed(value[7:0]);
        CFG_ANGLE_HIGH:  angle_high    = $signed(value[7:0]);
        CFG_DROP_MOVING: drop_moving   = value[0];
        CFG_OFFSET_POS:  offset_pos    = $signed(value[8:0]);
        CFG_OFFSET_NEG:  offset_neg    = $signed(value[8:0]);
        default: ;
      endcase
    endfunction

    // Largest whole degree whose sine does not exceed num/den, sign restored.
    function int arcsine_deg(longint num, longint den);
      longint mag, q, v;
      int     d;
      mag = (num < 0) ? -num : num;
      d   = RIGHT_ANGLE;
      if (mag < den) begin
        q = (mag << ASIN_TABLE_BITS) / den;
        v = q << (16 - ASIN_TABLE_BITS);
        d = RIGHT_ANGLE - 1;
        while (d > 0 && v < SINE_CEIL_Q16[d]) d--;
      end
      return (num < 0) ? -d : d;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_input(detection_t d);
      target_t     t;
      bit          kept;
      logic [2:0]  mode;
      longint      r, rng, spd, v, a, f;
      int          deg, ang;
      kept = 1'b0;
      rng  = 0;
      spd  = 0;
      ang  = 0;
      items_noted++;
      if (items_seen < MAX_TARGETS) begin
        items_seen++;
        mode = d.flags_a[5:3];
        if (mode == ENC_FIX_COARSE || mode == ENC_FIX_FINE) begin
          f   = (mode == ENC_FIX_COARSE) ? SCALE_COARSE : SCALE_FINE;
          r   = longint'(d.range_index) * range_step / (f * MM_IN_CM);
          spd = longint'(d.speed_index) * speed_step / (f * MM_IN_CM);
          deg = arcsine_deg(longint'(d.angle_index), f * BIN_HALF);
        end else begin
          r = longint'(d.range_index) * range_step / MM_IN_CM;
          v = longint'(d.speed_index);
          // Raw velocity and angle bins wrap round to negative values in the upper half.
          if (v >= velocity_bins / 2) v = v - velocity_bins;
          spd = v * speed_step / MM_IN_CM;
          a   = longint'(d.angle_index);
          if (a >= BIN_HALF) a = a - ANGLE_BINS;
          deg = arcsine_deg(a * 2, ANGLE_BINS);
        end
        rng = (r > RANGE_MAX_CM) ? RANGE_MAX_CM : r;
        if (spd > SPEED_MAX) spd = SPEED_MAX;
        if (spd < SPEED_MIN) spd = SPEED_MIN;
        if (kept_so_far < MAX_TARGETS && rng > 0 && deg >= angle_low && deg <= angle_high &&
            !(drop_moving && d.flags_a[7:6] <= MOVING_STATE_MAX)) begin
          kept = 1'b1;
          kept_so_far++;
          // A zero angle gets no offset at all.
          if (deg > 0) ang = deg + int'(offset_pos);
          else if (deg < 0) ang = deg + int'(offset_neg);
        end
      end
      if (!kept && !d.last) return;
      t.target_valid = kept;
      t.flags_a      = kept ? d.flags_a : '0;
      t.flags_b      = kept ? d.flags_b : '0;
      t.range_cm     = kept ? 15'(rng) : '0;
      t.speed_cm_s   = kept ? 16'(spd) : '0;
      t.angle_deg    = kept ? 10'(ang) : '0;
      t.power        = kept ? d.power : '0;
      t.frame_done   = d.last;
      t.kept_count   = 7'(kept_so_far);
      expected_q.push_back(t);
      if (d.last) begin
        kept_so_far = 0;
        items_seen  = 0;
      end
    endfunction

    function void compare(string field, longint want, longint got);
      if (want != got) begin
        errors++;
        $display("%0t ns: %s expected %0d, got %0d", $time, field, want, got);
      end
    endfunction

    function void check_result(target_t got);
      target_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t ns: result expected none, got target_valid %0d kept_count %0d",
                 $time, got.target_valid, got.kept_count);
        return;
      end
      want = expected_q.pop_front();
      results_seen++;
      if (got.frame_done) frames_seen++;
      if (got.target_valid) targets_kept++;
      compare("target_valid", want.target_valid, got.target_valid);
      compare("flags_a", want.flags_a, got.flags_a);
      compare("flags_b", want.flags_b, got.flags_b);
      compare("range_cm", want.range_cm, got.range_cm);
      compare("speed_cm_s", want.speed_cm_s, got.speed_cm_s);
      compare("angle_deg", want.angle_deg, got.angle_deg);
      compare("power", want.power, got.power);
      compare("frame_done", want.frame_done, got.frame_done);
      compare("kept_count", want.kept_count, got.kept_count);
    endfunction
  endclass

  logic         clk_i = 1'b0;
  logic         rst_ni;
  logic         cfg_we_i;
  logic [2:0]   cfg_index_i;
  logic [15:0]  cfg_wdata_i;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  // tdata from bit 0: flags_a[8], flags_b[8], power[32], range_index[32],
  // speed_index[32], angle_index[32].
  logic [143:0] s_axis_tdata;
  logic         s_axis_tlast;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  // tdata from bit 0: out_flags_a[8], out_flags_b[8], range_cm[15], speed_cm_s[16],
  // angle_deg[10], out_power[32], kept_count[7].
  logic [95:0]  m_axis_tdata;
  // tuser: target_valid[1].
  logic [0:0]   m_axis_tuser;
  logic         m_axis_tlast;

  target_scoreboard sb;

  // Idle probabilities in percent for each side, changed from one phase to the next.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  // Set by the stimulus to ask the receiver for one long hold-off.
  bit hold_off_req = 1'b0;
  int settings_used = 0;
  int stuck_cycles = 0;

  always #1 clk_i = ~clk_i;

  radar_point_target_converter i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Gap length in cycles: mostly none, otherwise short, now and then long.
  function automatic int pick_gap(int idle_pct);
    if (int'($urandom_range(99)) >= idle_pct) return 0;
    if ($urandom_range(7) == 0) return $urandom_range(40, 8);
    return $urandom_range(3, 1);
  endfunction

  function automatic logic [7:0] flag_byte(logic [1:0] motion, logic [2:0] mode,
                                           logic [2:0] spare);
    return {motion, mode, spare};
  endfunction

  function automatic detection_t detection(logic [7:0] fa, logic [7:0] fb, logic [31:0] pw,
                                           logic [31:0] ri, logic signed [31:0] vi,
                                           logic signed [31:0] ai, logic last);
    detection_t d;
    d.flags_a     = fa;
    d.flags_b     = fb;
    d.power       = pw;
    d.range_index = ri;
    d.speed_index = vi;
    d.angle_index = ai;
    d.last        = last;
    return d;
  endfunction

  // Random detection: mostly plausible indices for its mode, now and then any bit pattern.
  // Range and speed are spread over every magnitude by a random right shift.
  function automatic detection_t random_detection(logic last);
    detection_t d;
    int         pick;
    bit         wide;
    longint     den;
    pick          = $urandom_range(9);
    d.flags_a     = 8'($urandom);
    d.flags_a[5:3] = (pick < 4) ? ENC_FIX_COARSE :
                     (pick < 7) ? ENC_FIX_FINE : 3'($urandom_range(7));
    d.flags_b     = 8'($urandom);
    d.power       = $urandom;
    d.last        = last;
    wide          = ($urandom_range(7) == 0);
    d.range_index = $urandom >> $urandom_range(31);
    d.speed_index = $urandom >> $urandom_range(31);
    if ($urandom_range(1) == 1) d.speed_index = -d.speed_index;
    if (d.flags_a[5:3] == ENC_FIX_COARSE || d.flags_a[5:3] == ENC_FIX_FINE) begin
      den = (d.flags_a[5:3] == ENC_FIX_COARSE) ? COARSE_DEN : FINE_DEN;
      d.angle_index = 32'(longint'($urandom_range(0, 32'(2 * den + den / 4))) - den - den / 8);
    end else begin
      d.angle_index = $urandom_range(ANGLE_BINS - 1);
      if (!wide) d.speed_index = $urandom_range(255);
    end
    if (wide) d.angle_index = $urandom;
    return d;
  endfunction

  function automatic int frame_length();
    if ($urandom_range(9) == 0) return $urandom_range(90, 60);
    return $urandom_range(20, 1);
  endfunction

  // Offers one detection and returns at the edge where it was transferred. Valid stays
  // high afterwards, so the caller either offers the next item or lowers it.
  task automatic send_item(detection_t d);
    int gap;
    gap = pick_gap(send_idle_pct);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {d.angle_index, d.speed_index, d.range_index, d.power,
                      d.flags_b, d.flags_a};
    s_axis_tlast  <= d.last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_input(d);
  endtask

  // Stops offering and waits until every expected target has been checked, then lets
  // the pipeline settle, since dropped detections may still be inside it.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Writes all registers back to back; the block is idle whenever this is called.
  task automatic apply_settings(int reg_val [NUM_REGS]);
    for (int i = 0; i < NUM_REGS; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_index_i <= cfg_idx_e'(i);
      cfg_wdata_i <= 16'(reg_val[i]);
      @(posedge clk_i);
      sb.set_reg(cfg_idx_e'(i), reg_val[i]);
    end
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  // Random frames; optionally a long receiver hold-off early on and a full pause halfway.
  task automatic run_frames(int count, bit with_hold, bit with_pause);
    int left;
    left = frame_length();
    for (int sent = 0; sent < count; sent++) begin
      if (with_hold && sent == 30) hold_off_req = 1'b1;
      if (with_pause && sent == count / 2) drain();
      left--;
      send_item(random_detection(left == 0 || sent == count - 1));
      if (left == 0) left = frame_length();
    end
  endtask

  // Receiver: random stalls, and one long hold-off on request while the sender keeps
  // offering, so that the pipeline fills and the input is held back.
  initial begin : result_receiver
    int gap;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_off_req = 1'b0;
      end else begin
        gap = pick_gap(recv_idle_pct);
        if (gap > 0) begin
          m_axis_tready <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Every output transfer is unpacked and checked against the oldest expectation.
  always @(posedge clk_i) begin : result_monitor
    target_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.target_valid = m_axis_tuser[0];
      got.flags_a      = m_axis_tdata[7:0];
      got.flags_b      = m_axis_tdata[15:8];
      got.range_cm     = m_axis_tdata[30:16];
      got.speed_cm_s   = m_axis_tdata[46:31];
      got.angle_deg    = m_axis_tdata[56:47];
      got.power        = m_axis_tdata[88:57];
      got.kept_count   = m_axis_tdata[95:89];
      got.frame_done   = m_axis_tlast;
      sb.check_result(got);
    end
  end

  // The run is abandoned when neither side has made a transfer for too long.
  always @(posedge clk_i) begin : watchdog
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles, %0d results outstanding",
               STUCK_LIMIT, sb.pending());
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin : stimulus
    int reg_val [NUM_REGS];
    sb = new();
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_index_i   <= CFG_RANGE_STEP;
    cfg_wdata_i   <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tlast  <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings. Every encoding mode first, each with one motion state, then the
    // extremes of each field and the arcsine boundaries of each scale.
    settings_used = 1;
    send_idle_pct = 30;
    recv_idle_pct = 30;
    for (int m = 0; m < 8; m++) begin
      send_item(detection(flag_byte(2'(m), 3'(m), 3'(m)), 8'(m * 37), 32'(m * 1000003),
                          32'(100 + m * 7), 32'(m - 4), 32'(m * 9), 1'b0));
    end
    // Zero range: dropped, no transfer.
    send_item(detection(flag_byte(2'd3, ENC_RAW, 3'd0), 8'h55, 32'd1, 32'd0, 32'sd3,
                        32'sd5, 1'b0));
    // All ones: range and speed saturate high, the angle bin wraps to a huge value.
    send_item(detection(8'hFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'sh7FFF_FFFF,
                        32'sh7FFF_FFFF, 1'b0));
    // Most negative indices: speed saturates low, angle saturates to minus a right angle.
    send_item(detection(8'h00, 8'h00, 32'h0, 32'd1, 32'sh8000_0000, 32'sh8000_0000, 1'b0));
    send_item(detection(flag_byte(2'd2, ENC_RAW, 3'd1), 8'hA5, 32'hDEAD_BEEF, 32'd400,
                        32'sd31, 32'sd16, 1'b0));
    send_item(detection(flag_byte(2'd2, ENC_RAW, 3'd2), 8'h5A, 32'h1234_5678, 32'd401,
                        32'sd32, 32'sd32, 1'b0));
    send_item(detection(flag_byte(2'd2, ENC_RAW, 3'd3), 8'h3C, 32'h8000_0000, 32'd402,
                        32'sd63, 32'sd31, 1'b0));
    send_item(detection(flag_byte(2'd3, ENC_FIX_COARSE, 3'd0), 8'h01, 32'd7, 32'd40960,
                        -32'sd40960, 32'(COARSE_DEN), 1'b0));
    send_item(detection(flag_byte(2'd3, ENC_FIX_COARSE, 3'd0), 8'h02, 32'd8, 32'd81920,
                        32'sd40960, 32'(COARSE_DEN - 1), 1'b0));
    send_item(detection(flag_byte(2'd3, ENC_FIX_COARSE, 3'd0), 8'h03, 32'd9, 32'hFFFF_FFFF,
                        32'sd1, 32'(-COARSE_DEN), 1'b0));
    send_item(detection(flag_byte(2'd3, ENC_FIX_FINE, 3'd0), 8'h04, 32'd10, 32'd4096000,
                        32'sh7FFF_FFFF, 32'(FINE_DEN), 1'b0));
    send_item(detection(flag_byte(2'd3, ENC_FIX_FINE, 3'd0), 8'h05, 32'd11, 32'd8192000,
                        32'sh8000_0000, 32'(-FINE_DEN / 4), 1'b0));
    send_item(detection(flag_byte(2'd3, ENC_FIX_FINE, 3'd0), 8'h06, 32'd12, 32'd4096000,
                        32'sd0, 32'sd0, 1'b0));
    // A dropped last item still reports the frame count, then a one-item kept frame.
    send_item(detection(flag_byte(2'd2, ENC_RAW, 3'd0), 8'h77, 32'd13, 32'd0, 32'sd1,
                        32'sd1, 1'b1));
    send_item(detection(flag_byte(2'd2, ENC_RAW, 3'd0), 8'h88, 32'd14, 32'd1000, 32'sd2,
                        32'sd2, 1'b1));
    run_frames(150, 1'b1, 1'b1);
    drain();

    // Largest steps, offsets of 180 either way and motion filtering, with no idling at all.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    reg_val[CFG_RANGE_STEP]  = 65535;
    reg_val[CFG_SPEED_STEP]  = -32768;
    reg_val[CFG_VEL_BINS]    = 255;
    reg_val[CFG_ANGLE_LOW]   = -90;
    reg_val[CFG_ANGLE_HIGH]  = 90;
    reg_val[CFG_DROP_MOVING] = 1;
    reg_val[CFG_OFFSET_POS]  = 180;
    reg_val[CFG_OFFSET_NEG]  = -180;
    apply_settings(reg_val);
    // Zero angle takes no offset; positive and negative angles take their own.
    send_item(detection(flag_byte(2'd3, ENC_RAW, 3'd0), 8'h10, 32'd1, 32'd1, 32'sd1,
                        32'sd0, 1'b0));
    send_item(detection(flag_byte(2'd2, ENC_RAW, 3'd0), 8'h11, 32'd2, 32'd2, 32'sd126,
                        32'sd16, 1'b0));
    send_item(detection(flag_byte(2'd3, ENC_RAW, 3'd0), 8'h12, 32'd3, 32'd3, 32'sd127,
                        32'sd48, 1'b0));
    // Moving last item: dropped, yet it closes the frame.
    send_item(detection(flag_byte(2'd0, ENC_RAW, 3'd0), 8'h13, 32'd4, 32'd4, 32'sd5,
                        32'sd16, 1'b1));
    run_frames(120, 1'b0, 1'b0);
    drain();

    // Zero range step, empty angle window and no velocity wrap: only frame ends report.
    send_idle_pct = 50;
    recv_idle_pct = 10;
    reg_val[CFG_RANGE_STEP]  = 0;
    reg_val[CFG_SPEED_STEP]  = 32767;
    reg_val[CFG_VEL_BINS]    = 0;
    reg_val[CFG_ANGLE_LOW]   = 90;
    reg_val[CFG_ANGLE_HIGH]  = -90;
    reg_val[CFG_DROP_MOVING] = 0;
    reg_val[CFG_OFFSET_POS]  = -180;
    reg_val[CFG_OFFSET_NEG]  = 180;
    apply_settings(reg_val);
    run_frames(60, 1'b0, 1'b0);
    drain();

    // Random settings with a mix of idling profiles.
    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct = ($urandom_range(2) == 0) ? 0 : 40;
      recv_idle_pct = ($urandom_range(2) == 0) ? 0 : 40;
      reg_val[CFG_RANGE_STEP]  = $urandom_range(3000, 1);
      reg_val[CFG_SPEED_STEP]  = int'($urandom_range(65535)) - 32768;
      reg_val[CFG_VEL_BINS]    = $urandom_range(255);
      reg_val[CFG_ANGLE_LOW]   = int'($urandom_range(100)) - 90;
      reg_val[CFG_ANGLE_HIGH]  = int'($urandom_range(100)) - 10;
      reg_val[CFG_DROP_MOVING] = $urandom_range(1);
      reg_val[CFG_OFFSET_POS]  = int'($urandom_range(360)) - 180;
      reg_val[CFG_OFFSET_NEG]  = int'($urandom_range(360)) - 180;
      apply_settings(reg_val);
      run_frames(140, phase == 1, phase[0] == 1'b0);
      drain();
    end

    $display("Summary: %0d detections in %0d frames under %0d register settings,",
             sb.items_noted, sb.frames_seen, settings_used);
    $display("Summary: %0d results checked, %0d of them kept targets, %0d mismatches.",
             sb.results_seen, sb.targets_kept, sb.errors);
    if (sb.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/rpt_pkg.sv
sv/radar_point_target_converter.sv
bench/tb.sv
